>>> rtl/clq_pkg.sv
// clq_pkg: shared constants, types and ring index arithmetic for the
// circular list queue engine. No dependencies.
`timescale 1ns / 1ps

package clq_pkg;

	// Ring geometry
	localparam int DEPTH  = 64;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = CNT_W + 1;

	// Field widths
	localparam int CMD_W  = 3;
	localparam int VAL_W  = 32;
	localparam int STEP_W = 8;
	localparam int ST_W   = 2;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ROTATE = 3'd4;
	localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd5;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	// Memory request from the sequencer
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [VAL_W-1:0] wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	// Finished result handed to the output register
	typedef struct packed {
		logic [VAL_W-1:0] result_value;
		logic             is_empty;
		logic [ST_W-1:0]  status;
	} resp_t;

	// (base + off) modulo DEPTH; base < DEPTH and off <= DEPTH
	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
	                                              input logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(off);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

>>> rtl/circular_list_queue_engine_top.sv
// Rotate makes one ring copy per rotation (none when the ring is full); count makes one
// ring memory read per entry. One item in flight: a new item is accepted only after
// the result of the last one has been handed to the output register.
// Reset clears front index and occupancy; ring contents stay undefined.
// Depends on clq_pkg, clq_ram and clq_seq.
`timescale 1ns / 1ps

module circular_list_queue_engine_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [clq_pkg::CMD_W-1:0]     cmd,
	input  logic signed [clq_pkg::VAL_W-1:0] value,
	input  logic [clq_pkg::STEP_W-1:0]    steps,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [clq_pkg::VAL_W-1:0] result_value,
	output logic                          is_empty,
	output logic [clq_pkg::ST_W-1:0]      status
);

	clq_pkg::mem_req_t            mem_req;
	logic [clq_pkg::VAL_W-1:0]    mem_rdata;
	clq_pkg::resp_t               resp;
	logic                         resp_valid;
	logic                         out_free;
	logic                         out_valid_q;
	clq_pkg::resp_t               out_q;

	clq_ram #(
		.WIDTH(clq_pkg::VAL_W),
		.DEPTH(clq_pkg::DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	clq_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.value      (value),
		.steps      (steps),
		.mem_req    (mem_req),
		.mem_rdata  (mem_rdata),
		.resp_valid (resp_valid),
		.resp_take  (out_free),
		.resp       (resp)
	);

	// Output register: takes a result when empty or when its transfer completes
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= resp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && resp_valid) begin
			out_q <= resp;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_q.result_value;
	assign is_empty     = out_q.is_empty;
	assign status       = out_q.status;

endmodule

>>> rtl/clq_ram.sv
// clq_ram: generic single-write, single-read synchronous RAM with a
// registered read port. No dependencies.
`timescale 1ns / 1ps

module clq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/clq_seq.sv
// clq_seq: command sequencer holding front index and occupancy; drives the
// ring memory for insert, read, rotate and count. Depends on clq_pkg.
`timescale 1ns / 1ps

module clq_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [clq_pkg::CMD_W-1:0]     cmd,
	input  logic [clq_pkg::VAL_W-1:0]     value,
	input  logic [clq_pkg::STEP_W-1:0]    steps,
	output clq_pkg::mem_req_t             mem_req,
	input  logic [clq_pkg::VAL_W-1:0]     mem_rdata,
	output logic                          resp_valid,
	input  logic                          resp_take,
	output clq_pkg::resp_t                resp
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_ROT  = 3'd2;
	localparam logic [2:0] S_CNT  = 3'd3;
	localparam logic [2:0] S_RESP = 3'd4;

	logic [2:0]                   state_q, state_d;
	logic [clq_pkg::IDX_W-1:0]    front_q, front_d;
	logic [clq_pkg::CNT_W-1:0]    occ_q, occ_d;
	logic [clq_pkg::STEP_W-1:0]   steps_q, steps_d;
	logic                         full_q, full_d;
	logic [clq_pkg::CNT_W-1:0]    iss_q, iss_d;
	logic [clq_pkg::CNT_W-1:0]    cnt_q, cnt_d;
	logic [clq_pkg::VAL_W-1:0]    key_q, key_d;
	logic [clq_pkg::VAL_W-1:0]    res_q, res_d;
	logic [clq_pkg::ST_W-1:0]     st_q, st_d;
	logic                         fwd_q, fwd_d;
	logic [clq_pkg::VAL_W-1:0]    fwd_data_q, fwd_data_d;

	logic [clq_pkg::VAL_W-1:0]    rdat;
	logic                         is_full;
	logic [clq_pkg::IDX_W-1:0]    next_front;

	// Read data, bypassed when the entry was written in the same cycle it was read
	assign rdat       = fwd_q ? fwd_data_q : mem_rdata;
	assign is_full    = (occ_q == clq_pkg::CNT_W'(clq_pkg::DEPTH));
	assign next_front = clq_pkg::ring_add(front_q, clq_pkg::CNT_W'(1));
	assign in_stall   = (state_q != S_IDLE);

	assign resp_valid        = (state_q == S_RESP);
	assign resp.result_value = res_q;
	assign resp.is_empty     = (occ_q == '0);
	assign resp.status       = st_q;

	// Next-state and memory request logic
	always_comb begin
		state_d    = state_q;
		front_d    = front_q;
		occ_d      = occ_q;
		steps_d    = steps_q;
		full_d     = full_q;
		iss_d      = iss_q;
		cnt_d      = cnt_q;
		key_d      = key_q;
		res_d      = res_q;
		st_d       = st_q;
		fwd_d      = 1'b0;
		fwd_data_d = fwd_data_q;
		mem_req    = '0;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					res_d   = '0;
					st_d    = clq_pkg::ST_OK;
					state_d = S_RESP;
					case (cmd)
						clq_pkg::CMD_CLEAR: begin
							front_d = '0;
							occ_d   = '0;
						end
						clq_pkg::CMD_INSERT: begin
							if (is_full) begin
								st_d = clq_pkg::ST_FULL;
							end else begin
								mem_req.we    = 1'b1;
								mem_req.waddr = clq_pkg::ring_add(front_q, occ_q);
								mem_req.wdata = value;
								occ_d         = occ_q + clq_pkg::CNT_W'(1);
							end
						end
						clq_pkg::CMD_REMOVE: begin
							if (occ_q != '0) begin
								front_d = next_front;
								occ_d   = occ_q - clq_pkg::CNT_W'(1);
							end
						end
						clq_pkg::CMD_READ: begin
							if (occ_q == '0) begin
								st_d = clq_pkg::ST_EMPTY;
							end else begin
								mem_req.re    = 1'b1;
								mem_req.raddr = front_q;
								state_d       = S_READ;
							end
						end
						clq_pkg::CMD_ROTATE: begin
							if (occ_q != '0 && steps != '0) begin
								steps_d = steps;
								full_d  = is_full;
								state_d = S_ROT;
								if (!is_full) begin
									mem_req.re    = 1'b1;
									mem_req.raddr = front_q;
								end
							end
						end
						clq_pkg::CMD_COUNT: begin
							key_d = value;
							cnt_d = '0;
							if (occ_q != '0) begin
								mem_req.re    = 1'b1;
								mem_req.raddr = front_q;
								iss_d         = clq_pkg::CNT_W'(1);
								state_d       = S_CNT;
							end
						end
						default: begin
						end
					endcase
				end
			end

			S_READ: begin
				res_d   = rdat;
				state_d = S_RESP;
			end

			// One rotation per cycle: copy front to back (not when the ring is full), next read overlaps the write
			S_ROT: begin
				front_d = next_front;
				steps_d = steps_q - clq_pkg::STEP_W'(1);
				if (!full_q) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = clq_pkg::ring_add(front_q, occ_q);
					mem_req.wdata = rdat;
					if (steps_q != clq_pkg::STEP_W'(1)) begin
						mem_req.re    = 1'b1;
						mem_req.raddr = next_front;
						fwd_d         = (next_front == mem_req.waddr);
						fwd_data_d    = rdat;
					end
				end
				if (steps_q == clq_pkg::STEP_W'(1)) begin
					state_d = S_RESP;
				end
			end

			// Compare the entry read last cycle, issue the next offset
			S_CNT: begin
				if (rdat == key_q) begin
					cnt_d = cnt_q + clq_pkg::CNT_W'(1);
				end
				if (iss_q == occ_q) begin
					res_d   = clq_pkg::VAL_W'(cnt_d);
					state_d = S_RESP;
				end else begin
					mem_req.re    = 1'b1;
					mem_req.raddr = clq_pkg::ring_add(front_q, iss_q);
					iss_d         = iss_q + clq_pkg::CNT_W'(1);
				end
			end

			S_RESP: begin
				if (resp_take) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			front_q <= '0;
			occ_q   <= '0;
			fwd_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			occ_q   <= occ_d;
			fwd_q   <= fwd_d;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		steps_q    <= steps_d;
		full_q     <= full_d;
		iss_q      <= iss_d;
		cnt_q      <= cnt_d;
		key_q      <= key_d;
		res_q      <= res_d;
		st_q       <= st_d;
		fwd_data_q <= fwd_data_d;
	end

endmodule

>>> verif/tb.sv
// tb: self-checking testbench for circular_list_queue_engine_top. A directed table and
// random command streams run through an independent queue predictor.
// Depends on clq_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb;
	import clq_pkg::*;

	// Spare command codes, which the engine must ignore
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	// Longest legal quiet stretch: a maximal rotate plus stall runs, or the final wait
	localparam int QUIET_LIMIT = 5000;
	localparam int TAIL_CYCLES = 300;
	localparam int PHASE_ITEMS = 125;
	localparam int FILL_ITEMS  = 100;
	localparam int PLAN_ROWS   = 22;

	typedef struct {
		logic [CMD_W-1:0]  c;
		logic [VAL_W-1:0]  v;
		logic [STEP_W-1:0] n;
		bit                typed;
		resp_t             res;
	} plan_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CMD_W-1:0] cmd = CMD_CLEAR;
	logic signed [VAL_W-1:0] value = '0;
	logic [STEP_W-1:0] steps = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [VAL_W-1:0] result_value;
	logic is_empty;
	logic [ST_W-1:0] status;

	// Typed expectation travels with the item it belongs to
	bit    row_typed = 1'b0;
	resp_t row_res = '0;

	int idle_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	// Predictor state
	logic [VAL_W-1:0] ring_copy [DEPTH];
	logic [IDX_W-1:0] q_front = '0;
	logic [CNT_W-1:0] q_count = '0;
	resp_t pending_results [$];

	plan_row_t plan [PLAN_ROWS];

	circular_list_queue_engine_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.value(value),
		.steps(steps),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_value(result_value),
		.is_empty(is_empty),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one command to the predicted queue and returns its result
	function automatic resp_t queue_apply(input logic [CMD_W-1:0] c,
	                                      input logic [VAL_W-1:0] v,
	                                      input logic [STEP_W-1:0] n);
		resp_t r;
		int i;
		r = '0;
		case (c)
		CMD_CLEAR: begin
			q_count = '0;
			q_front = '0;
		end
		CMD_INSERT: begin
			if (q_count == DEPTH) begin
				r.status = ST_FULL;
			end else begin
				ring_copy[(q_front + q_count) % DEPTH] = v;
				q_count = q_count + 1'b1;
			end
		end
		CMD_REMOVE: begin
			if (q_count != 0) begin
				q_front = IDX_W'((q_front + 1) % DEPTH);
				q_count = q_count - 1'b1;
			end
		end
		CMD_READ: begin
			if (q_count == 0)
				r.status = ST_EMPTY;
			else
				r.result_value = ring_copy[q_front];
		end
		CMD_ROTATE: begin
			// a full ring only moves its front; the copy lands on itself
			for (i = 0; i < n; i++) begin
				if (q_count != 0) begin
					ring_copy[(q_front + q_count) % DEPTH] = ring_copy[q_front];
					q_front = IDX_W'((q_front + 1) % DEPTH);
				end
			end
		end
		CMD_COUNT: begin
			for (i = 0; i < q_count; i++) begin
				if (ring_copy[(q_front + i) % DEPTH] == v)
					r.result_value = r.result_value + 1;
			end
		end
		default: begin
		end
		endcase
		r.is_empty = (q_count == 0);
		return r;
	endfunction

	// Receiver stall
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Predict on each input transfer, check each output transfer, watch for hangs
	always @(posedge clk) begin
		resp_t pred;
		resp_t want;
		bit moved;
		moved = 1'b0;
		if (arst_n && in_valid && !in_stall) begin
			pred = queue_apply(cmd, value, steps);
			pending_results.push_back(row_typed ? row_res : pred);
			moved = 1'b1;
		end
		if (arst_n && out_valid && !out_stall) begin
			moved = 1'b1;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result value=%h empty=%b status=%0d",
						$time, result_value, is_empty, status);
			end else begin
				want = pending_results.pop_front();
				if (result_value !== want.result_value || is_empty !== want.is_empty ||
				    status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch value exp=%h got=%h empty exp=%b got=%b status exp=%0d got=%0d",
							$time, want.result_value, result_value, want.is_empty, is_empty,
							want.status, status);
				end
			end
		end
		quiet_cycles = (moved || !arst_n) ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("circular_list_queue_engine_top verification failed");
			$finish;
		end
	end

	// One transfer on the input side; valid stays high for back-to-back items
	task automatic send_item(input logic [CMD_W-1:0] c, input logic [VAL_W-1:0] v,
	                         input logic [STEP_W-1:0] n, input bit typed, input resp_t res);
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
		in_valid  <= 1'b1;
		cmd       <= c;
		value     <= v;
		steps     <= n;
		row_typed <= typed;
		row_res   <= res;
		do @(posedge clk); while (in_stall);
	endtask

	// Sender holds off until every predicted result has come back
	task automatic drain_queue();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Values from a small pool make count matches likely
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
		0: return 32'h0000_0000;
		1: return 32'hFFFF_FFFF;
		2: return 32'h8000_0000;
		3: return 32'h7FFF_FFFF;
		4: return 32'h0000_0001;
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [STEP_W-1:0] pick_steps();
		case ($urandom_range(0, 9))
		0: return 8'hFF;
		1: return STEP_W'($urandom_range(60, 70));
		2, 3, 4: return STEP_W'($urandom_range(0, 255));
		default: return STEP_W'($urandom_range(0, 7));
		endcase
	endfunction

	// Fill mode leans on insert so the ring reaches full; drain mode empties it
	task automatic pick_item(input bit fill, output logic [CMD_W-1:0] c,
	                         output logic [VAL_W-1:0] v, output logic [STEP_W-1:0] n);
		int roll;
		roll = $urandom_range(0, 99);
		v = pick_value();
		n = pick_steps();
		if (roll < 2)
			c = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
		else if (fill) begin
			if (roll < 77)      c = CMD_INSERT;
			else if (roll < 80) c = CMD_REMOVE;
			else if (roll < 87) c = CMD_READ;
			else if (roll < 93) c = CMD_ROTATE;
			else                c = CMD_COUNT;
		end else begin
			if (roll < 5)       c = CMD_CLEAR;
			else if (roll < 30) c = CMD_INSERT;
			else if (roll < 60) c = CMD_REMOVE;
			else if (roll < 75) c = CMD_READ;
			else if (roll < 87) c = CMD_ROTATE;
			else                c = CMD_COUNT;
		end
	endtask

	initial begin
		int idle_by_phase [4];
		int stall_by_phase [4];
		logic [CMD_W-1:0] c;
		logic [VAL_W-1:0] v;
		logic [STEP_W-1:0] n;

		idle_by_phase  = '{0, 80, 0, 8};
		stall_by_phase = '{0, 0, 80, 8};

		// Directed rows; typed results where they are plain, predictor elsewhere
		plan = '{
			'{CMD_READ,     32'h0000_0000, 8'd0,   1'b1, '{32'h0, 1'b1, ST_EMPTY}},
			'{CMD_REMOVE,   32'h0000_0000, 8'd0,   1'b1, '{32'h0, 1'b1, ST_OK}},
			'{CMD_ROTATE,   32'h0000_0000, 8'd5,   1'b1, '{32'h0, 1'b1, ST_OK}},
			'{CMD_COUNT,    32'h0000_0000, 8'd0,   1'b1, '{32'h0, 1'b1, ST_OK}},
			'{CMD_INSERT,   32'h8000_0000, 8'd0,   1'b1, '{32'h0, 1'b0, ST_OK}},
			'{CMD_INSERT,   32'h7FFF_FFFF, 8'd255, 1'b1, '{32'h0, 1'b0, ST_OK}},
			'{CMD_READ,     32'h0000_0000, 8'd0,   1'b1, '{32'h8000_0000, 1'b0, ST_OK}},
			'{CMD_COUNT,    32'h7FFF_FFFF, 8'd0,   1'b1, '{32'h1, 1'b0, ST_OK}},
			'{CMD_INSERT,   32'h7FFF_FFFF, 8'd0,   1'b0, '0},
			'{CMD_COUNT,    32'h7FFF_FFFF, 8'd0,   1'b0, '0},
			'{CMD_ROTATE,   32'h0000_0000, 8'd0,   1'b1, '{32'h0, 1'b0, ST_OK}},
			'{CMD_ROTATE,   32'h0000_0000, 8'd255, 1'b0, '0},
			'{CMD_READ,     32'h0000_0000, 8'd0,   1'b0, '0},
			'{CMD_SPARE_LO, 32'hFFFF_FFFF, 8'd255, 1'b1, '{32'h0, 1'b0, ST_OK}},
			'{CMD_SPARE_HI, 32'h0000_0000, 8'd0,   1'b1, '{32'h0, 1'b0, ST_OK}},
			'{CMD_REMOVE,   32'h0000_0000, 8'd0,   1'b0, '0},
			'{CMD_INSERT,   32'hFFFF_FFFF, 8'd0,   1'b0, '0},
			'{CMD_COUNT,    32'hFFFF_FFFF, 8'd0,   1'b0, '0},
			'{CMD_CLEAR,    32'hFFFF_FFFF, 8'd255, 1'b1, '{32'h0, 1'b1, ST_OK}},
			'{CMD_READ,     32'h0000_0000, 8'd0,   1'b1, '{32'h0, 1'b1, ST_EMPTY}},
			'{CMD_INSERT,   32'h0000_0000, 8'd0,   1'b1, '{32'h0, 1'b0, ST_OK}},
			'{CMD_REMOVE,   32'h0000_0000, 8'd0,   1'b1, '{32'h0, 1'b1, ST_OK}}
		};

		// Reset once at the start
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_item(plan[i].c, plan[i].v, plan[i].n, plan[i].typed, plan[i].res);
		drain_queue();

		// Random phases, each ending with a full drain by the sender
		for (int p = 0; p < 4; p++) begin
			idle_pct  = idle_by_phase[p];
			stall_pct = stall_by_phase[p];
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				pick_item(k < FILL_ITEMS, c, v, n);
				send_item(c, v, n, 1'b0, '0);
			end
			drain_queue();
		end

		// Catch stray results after the last expected one
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("circular_list_queue_engine_top verification clean");
		else
			$display("circular_list_queue_engine_top verification failed");
		$finish;
	end

endmodule
